FILE: hw/rtl/tmpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmpc_pkg
// shared types, constants and helpers of the temperature and humidity
// compensation pipeline
// ----------------------------------------------------------------------------
package tmpc_pkg;

   localparam int TempStages    = 5;
   localparam int HumStages     = 11;
   localparam int NumStages     = TempStages + HumStages;

   localparam int ReqDataWidth  = 40;
   localparam int RspDataWidth  = 40;
   localparam int TempWidth     = 16;
   localparam int HumWidth      = 17;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 32;

   localparam logic [CsrIndexWidth-1:0] CSR_TEMP_CAL_ONE         = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_TEMP_CAL_TWO         = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_TEMP_CAL_THREE       = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_HUM_CAL_ONE          = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_HUM_CAL_TWO          = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_HUM_CAL_SIGNED_BYTES = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_HUM_CAL_SIX          = 3'd6;

   localparam logic [26:0]         Recip100      = 27'd85899346;
   localparam int                  Recip100Shift = 33;
   localparam logic signed [24:0]  TempRound     = 25'sd128;
   localparam logic signed [20:0]  HumOffset     = 21'sd16384;
   localparam logic signed [10:0]  HumScale      = 11'sd1000;
   localparam logic [HumWidth-1:0] HumMax        = 17'd100000;

   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [7:0]  t3;
      logic [11:0] h1;
      logic [11:0] h2;
      logic [7:0]  h3;
      logic [7:0]  h4;
      logic [7:0]  h5;
      logic [7:0]  h7;
      logic [7:0]  h6;
   } cal_type;

   typedef struct packed {
      logic [16:0] tc;
      logic [15:0] tout;
      logic        sat;
      logic [15:0] adc_h;
   } temp_res_type;

   typedef struct packed {
      logic [HumWidth-1:0]  humidity;
      logic [TempWidth-1:0] temperature;
      logic                 sat;
   } rsp_type;

   // signed divide by 100, truncating toward zero, exact for 26-bit inputs
   function automatic logic signed [25:0] div100(input logic signed [25:0] x);
      logic [25:0] mag;
      logic [52:0] prod;
      logic [25:0] quo;
      mag  = x[25] ? 26'(-x) : 26'(x);
      prod = 53'(mag) * 53'(Recip100);
      quo  = 26'(prod[52:Recip100Shift]);
      return x[25] ? -$signed(quo) : $signed(quo);
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/tmpc_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmpc_csr
// calibration register file, written through the csr channel
// ----------------------------------------------------------------------------
module tmpc_csr
   import tmpc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data,
   output cal_type                  cal
);

   cal_type cal_ff;
   cal_type cal_in;

   assign csr_ready = 1'b1;
   assign cal       = cal_ff;

   always_comb begin
      cal_in = cal_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TEMP_CAL_ONE:   cal_in.t1 = csr_data[15:0];
            CSR_TEMP_CAL_TWO:   cal_in.t2 = csr_data[15:0];
            CSR_TEMP_CAL_THREE: cal_in.t3 = csr_data[7:0];
            CSR_HUM_CAL_ONE:    cal_in.h1 = csr_data[11:0];
            CSR_HUM_CAL_TWO:    cal_in.h2 = csr_data[11:0];
            CSR_HUM_CAL_SIGNED_BYTES: begin
               cal_in.h3 = csr_data[7:0];
               cal_in.h4 = csr_data[15:8];
               cal_in.h5 = csr_data[23:16];
               cal_in.h7 = csr_data[31:24];
            end
            CSR_HUM_CAL_SIX:    cal_in.h6 = csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else begin
         cal_ff <= cal_in;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/tmpc_flow.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmpc_flow
// valid bits and per-stage load enables of the pipeline
// ----------------------------------------------------------------------------
module tmpc_flow
   import tmpc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [NumStages-1:0] stage_en
);

   logic [NumStages-1:0] valid_ff;
   logic [NumStages-1:0] valid_in;

   // a stage loads when it is empty or its content moves on
   always_comb begin
      stage_en[NumStages-1] = !valid_ff[NumStages-1] || out_ready;
      for (int k = NumStages - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (stage_en[0]) begin
         valid_in[0] = in_valid;
      end
      for (int k = 1; k < NumStages; k++) begin
         if (stage_en[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = stage_en[0];
   assign out_valid = valid_ff[NumStages-1];

endmodule
`default_nettype wire

FILE: hw/rtl/tmpc_temp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmpc_temp
// temperature stages: unpack, linear and square terms, scaling, saturation
// ----------------------------------------------------------------------------
module tmpc_temp
   import tmpc_pkg::*;
(
   input  logic                    clock,
   input  logic [TempStages-1:0]   stage_en,
   input  logic [ReqDataWidth-1:0] req_data,
   input  cal_type                 cal,
   output temp_res_type            temp_res
);

   localparam logic [15:0] TempPosSat = 16'h7fff;
   localparam logic [15:0] TempNegSat = 16'h8000;

   logic [19:0]        adc_t;
   logic [15:0]        adc_h_in;
   logic [15:0]        adc_h_ff [TempStages];

   logic signed [18:0] a_t_in,  a_t_ff;
   logic signed [17:0] half;
   logic signed [34:0] pb_full;
   logic signed [35:0] psq_full;
   logic signed [31:0] pb_in,   pb_ff;
   logic signed [31:0] psq_in,  psq_ff;
   logic signed [20:0] b_in,    b_ff;
   logic signed [31:0] c1_in,   c1_ff;
   logic signed [17:0] c_term;
   logic signed [21:0] fine;
   logic signed [24:0] f5;
   logic signed [16:0] tc_in,   tc_ff;
   logic signed [16:0] tc5_ff;
   logic [15:0]        tout_in, tout_ff;
   logic               sat_in,  sat_ff;

   // stage 1: unpack and offset
   always_comb begin
      adc_t    = {req_data[7:0], req_data[15:8], req_data[23:20]};
      adc_h_in = {req_data[31:24], req_data[39:32]};
      a_t_in   = $signed(19'(adc_t[19:3]) - 19'({cal.t1, 1'b0}));
   end

   // stage 2: linear and square products
   always_comb begin
      half     = 18'(a_t_ff >>> 1);
      pb_full  = a_t_ff * $signed(cal.t2);
      psq_full = half * half;
      pb_in    = pb_full[31:0];
      psq_in   = psq_full[31:0];
   end

   // stage 3: square term gain
   always_comb begin
      b_in  = pb_ff[31:11];
      c1_in = $signed(psq_ff[31:12]) * $signed({cal.t3, 4'b0});
   end

   // stage 4: fine temperature and scaling
   always_comb begin
      c_term = c1_ff[31:14];
      fine   = b_ff + c_term;
      f5     = (25'(fine) <<< 2) + 25'(fine) + TempRound;
      tc_in  = f5[24:8];
   end

   // stage 5: saturation
   always_comb begin
      if (tc_ff[16] != tc_ff[15]) begin
         tout_in = tc_ff[16] ? TempNegSat : TempPosSat;
         sat_in  = 1'b1;
      end else begin
         tout_in = tc_ff[15:0];
         sat_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         a_t_ff      <= a_t_in;
         adc_h_ff[0] <= adc_h_in;
      end
      if (stage_en[1]) begin
         pb_ff  <= pb_in;
         psq_ff <= psq_in;
      end
      if (stage_en[2]) begin
         b_ff  <= b_in;
         c1_ff <= c1_in;
      end
      if (stage_en[3]) begin
         tc_ff <= tc_in;
      end
      if (stage_en[4]) begin
         tc5_ff  <= tc_ff;
         tout_ff <= tout_in;
         sat_ff  <= sat_in;
      end
      for (int k = 1; k < TempStages; k++) begin
         if (stage_en[k]) begin
            adc_h_ff[k] <= adc_h_ff[k-1];
         end
      end
   end

   always_comb begin
      temp_res.tc    = tc5_ff;
      temp_res.tout  = tout_ff;
      temp_res.sat   = sat_ff;
      temp_res.adc_h = adc_h_ff[TempStages-1];
   end

endmodule
`default_nettype wire

FILE: hw/rtl/tmpc_hum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmpc_hum
// humidity stages: temperature corrections, gain, square term, clamp
// ----------------------------------------------------------------------------
module tmpc_hum
   import tmpc_pkg::*;
(
   input  logic                 clock,
   input  logic [HumStages-1:0] stage_en,
   input  cal_type              cal,
   input  temp_res_type         temp_res,
   output rsp_type              rsp
);

   logic [TempWidth-1:0] tout_ff [HumStages];
   logic                 sat_ff  [HumStages];
   logic signed [16:0]   tc_ff   [2];
   logic [15:0]          adc_h_ff [2];

   logic signed [16:0] tc_s;
   logic signed [24:0] m3_in, m4_in, m5_in, m7_in;
   logic signed [24:0] m3_ff, m4_ff, m5_ff, m7_ff;
   logic signed [17:0] e3_in, g1_in, d5_in, e7_in;
   logic signed [17:0] e3_ff, g1_ff, d5_ff, e7_ff;
   logic signed [19:0] adc_h_s, h1_s, e3_half;
   logic signed [19:0] a_h_in, a_h_ff, a_h4_ff, a_h5_ff;
   logic signed [34:0] p2_full;
   logic signed [31:0] p2_in, p2_ff;
   logic signed [18:0] w_sum;
   logic signed [14:0] w_in, w_ff, w4_ff, w5_ff, w6_ff, w7_ff;
   logic signed [17:0] g1_3_ff, g1_4_ff;
   logic signed [19:0] g2_in, g2_ff;
   logic signed [20:0] gsum;
   logic signed [33:0] pbh_full;
   logic signed [31:0] pbh_in, pbh_ff;
   logic signed [41:0] q_full;
   logic signed [31:0] q_in, q_ff, q7_ff, q8_ff;
   logic signed [17:0] r_val;
   logic signed [35:0] pr_full;
   logic signed [31:0] pr_in, pr_ff;
   logic signed [36:0] pw_full;
   logic signed [31:0] pw_in, pw_ff;
   logic signed [30:0] v6;
   logic [31:0]        sum32;
   logic signed [21:0] s_in, s_ff;
   logic signed [32:0] p1000_full;
   logic signed [31:0] p1000_in, p1000_ff;
   logic signed [19:0] hum_raw;
   logic [HumWidth-1:0] hum_in, hum_ff;

   // stage 1: temperature times signed calibration bytes
   always_comb begin
      tc_s  = temp_res.tc;
      m3_in = tc_s * $signed(cal.h3);
      m4_in = tc_s * $signed(cal.h4);
      m5_in = tc_s * $signed(cal.h5);
      m7_in = tc_s * $signed(cal.h7);
   end

   // stage 2: divide by 100
   always_comb begin
      e3_in = 18'(div100(26'(m3_ff)));
      g1_in = 18'(div100(26'(m4_ff)));
      d5_in = 18'(div100(26'(m5_ff)));
      e7_in = 18'(div100(26'(m7_ff)));
   end

   // stage 3: offset, second order product, square term weight
   always_comb begin
      adc_h_s = $signed({4'b0, adc_h_ff[1]});
      h1_s    = $signed({4'b0, cal.h1, 4'b0});
      e3_half = 20'(e3_ff >>> 1);
      a_h_in  = adc_h_s - h1_s - e3_half;
      p2_full = tc_ff[1] * d5_ff;
      p2_in   = p2_full[31:0];
      w_sum   = $signed({4'b0, cal.h6, 7'b0}) + 19'(e7_ff);
      w_in    = w_sum[18:4];
   end

   // stage 4: second order correction
   always_comb begin
      g2_in = 20'(div100($signed(p2_ff[31:6])));
   end

   // stage 5: gain
   always_comb begin
      gsum     = 21'(g1_4_ff) + 21'(g2_ff) + HumOffset;
      pbh_full = $signed({1'b0, cal.h2}) * gsum;
      pbh_in   = pbh_full[31:0];
   end

   // stage 6: main product
   always_comb begin
      q_full = a_h5_ff * $signed(pbh_ff[31:10]);
      q_in   = q_full[31:0];
   end

   // stage 7: square of the scaled product
   always_comb begin
      r_val   = q_ff[31:14];
      pr_full = r_val * r_val;
      pr_in   = pr_full[31:0];
   end

   // stage 8: weighted square term
   always_comb begin
      pw_full = w7_ff * $signed(pr_ff[31:10]);
      pw_in   = pw_full[31:0];
   end

   // stage 9: sum
   always_comb begin
      v6    = pw_ff[31:1];
      sum32 = 32'(q8_ff) + 32'(v6);
      s_in  = sum32[31:10];
   end

   // stage 10: scale to thousandths
   always_comb begin
      p1000_full = s_ff * HumScale;
      p1000_in   = p1000_full[31:0];
   end

   // stage 11: clamp
   always_comb begin
      hum_raw = p1000_ff[31:12];
      if (hum_raw[19]) begin
         hum_in = '0;
      end else if (hum_raw[18:0] > 19'(HumMax)) begin
         hum_in = HumMax;
      end else begin
         hum_in = hum_raw[HumWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         m3_ff       <= m3_in;
         m4_ff       <= m4_in;
         m5_ff       <= m5_in;
         m7_ff       <= m7_in;
         tc_ff[0]    <= temp_res.tc;
         adc_h_ff[0] <= temp_res.adc_h;
         tout_ff[0]  <= temp_res.tout;
         sat_ff[0]   <= temp_res.sat;
      end
      if (stage_en[1]) begin
         e3_ff       <= e3_in;
         g1_ff       <= g1_in;
         d5_ff       <= d5_in;
         e7_ff       <= e7_in;
         tc_ff[1]    <= tc_ff[0];
         adc_h_ff[1] <= adc_h_ff[0];
      end
      if (stage_en[2]) begin
         a_h_ff  <= a_h_in;
         p2_ff   <= p2_in;
         w_ff    <= w_in;
         g1_3_ff <= g1_ff;
      end
      if (stage_en[3]) begin
         g2_ff   <= g2_in;
         g1_4_ff <= g1_3_ff;
         a_h4_ff <= a_h_ff;
         w4_ff   <= w_ff;
      end
      if (stage_en[4]) begin
         pbh_ff  <= pbh_in;
         a_h5_ff <= a_h4_ff;
         w5_ff   <= w4_ff;
      end
      if (stage_en[5]) begin
         q_ff  <= q_in;
         w6_ff <= w5_ff;
      end
      if (stage_en[6]) begin
         pr_ff <= pr_in;
         q7_ff <= q_ff;
         w7_ff <= w6_ff;
      end
      if (stage_en[7]) begin
         pw_ff <= pw_in;
         q8_ff <= q7_ff;
      end
      if (stage_en[8]) begin
         s_ff <= s_in;
      end
      if (stage_en[9]) begin
         p1000_ff <= p1000_in;
      end
      if (stage_en[10]) begin
         hum_ff <= hum_in;
      end
      for (int k = 1; k < HumStages; k++) begin
         if (stage_en[k]) begin
            tout_ff[k] <= tout_ff[k-1];
            sat_ff[k]  <= sat_ff[k-1];
         end
      end
   end

   always_comb begin
      rsp.humidity    = hum_ff;
      rsp.temperature = tout_ff[HumStages-1];
      rsp.sat         = sat_ff[HumStages-1];
   end

endmodule
`default_nettype wire

FILE: hw/rtl/temp_humidity_compensation.sv
`default_nettype none
// Compensates one raw temperature and humidity measurement per transaction
// with the integer formulas of the sensor and the calibration words written
// through the csr channel. A new measurement is taken every clock cycle unless
// the pipeline is full and rsp_tready holds it; each result passes through the
// 16 register stages of the datapath (5 for temperature, 11 for humidity),
// the first of which loads on the accepting edge, and is offered on rsp from
// the last stage register. The
// pipeline keeps a valid bit per stage and closes up empty stages, so it
// still takes requests while a result waits on rsp_tready until every stage
// is full. Calibration writes are taken in any cycle and must only be made
// while no measurement is in flight.
// ----------------------------------------------------------------------------
// temp_humidity_compensation
// pipelined temperature and humidity compensation, top level
// ----------------------------------------------------------------------------
module temp_humidity_compensation
   import tmpc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // temp_msb, temp_lsb, temp_xlsb, hum_msb, hum_lsb
   input  logic [ReqDataWidth-1:0]  req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // temperature_centideg, humidity_millipct, zero fill
   output logic [RspDataWidth-1:0]  rsp_tdata,
   // temp_saturated
   output logic [0:0]               rsp_tuser,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   cal_type              cal;
   temp_res_type         temp_res;
   rsp_type              rsp;
   logic [NumStages-1:0] stage_en;

   tmpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cal       (cal)
   );

   tmpc_flow u_flow (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .stage_en  (stage_en)
   );

   tmpc_temp u_temp (
      .clock    (clock),
      .stage_en (stage_en[TempStages-1:0]),
      .req_data (req_tdata),
      .cal      (cal),
      .temp_res (temp_res)
   );

   tmpc_hum u_hum (
      .clock    (clock),
      .stage_en (stage_en[NumStages-1:TempStages]),
      .cal      (cal),
      .temp_res (temp_res),
      .rsp      (rsp)
   );

   assign rsp_tdata = {{(RspDataWidth-TempWidth-HumWidth){1'b0}},
                       rsp.humidity, rsp.temperature};
   assign rsp_tuser = rsp.sat;

endmodule
`default_nettype wire

FILE: hw/rtl/tmpc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmpc_checker
// port level checks of the compensation pipeline, bound to the top level
// ----------------------------------------------------------------------------
module tmpc_checker
   import tmpc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tready,
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [RspDataWidth-1:0] rsp_tdata,
   input  logic [0:0]              rsp_tuser
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp changed while stalled");

   // input stalls only when the whole pipe is backed up
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req stalled without rsp backpressure");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[TempWidth+HumWidth-1:TempWidth] <= HumMax)
      else $error("humidity above clamp");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         rsp_tdata[TempWidth-1:0] == 16'h7fff || rsp_tdata[TempWidth-1:0] == 16'h8000)
      else $error("saturation flag without limit value");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind temp_humidity_compensation tmpc_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

FILE: dv/temp_humidity_compensation_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// temp_humidity_compensation_tb
// self-checking bench for the temperature and humidity compensation pipeline:
// raw measurements stream in under random valid and ready gaps, each accepted
// transaction is run through an integer compensation predictor with its own
// copy of the calibration words, and every result is compared field by field
// with the oldest prediction. calibration is reloaded between phases (reset,
// typical, both extremes and random sets) once the pipeline has drained.
// ----------------------------------------------------------------------------
module temp_humidity_compensation_tb;
   import tmpc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CsrIndexWidth-1:0] CsrUnmapped = 3'd7;
   localparam int DrainCycles      = NumStages + 8;
   localparam int WatchdogLimit    = 2000;
   localparam int RandomPhases     = 8;
   localparam int ItemsPerPhase    = 250;
   localparam int LongStallCycles  = 80;
   localparam int MaxReports       = 100;

   typedef struct packed {
      logic [TempWidth-1:0] temperature;
      logic [HumWidth-1:0]  humidity;
      logic                 sat;
   } comp_reading_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [ReqDataWidth-1:0]  req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RspDataWidth-1:0]  rsp_tdata;
   logic [0:0]               rsp_tuser;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_data = '0;

   // calibration as the block should hold it
   logic [15:0] cal_t1 = '0;
   logic [15:0] cal_t2 = '0;
   logic [7:0]  cal_t3 = '0;
   logic [11:0] cal_h1 = '0;
   logic [11:0] cal_h2 = '0;
   logic [31:0] cal_hbytes = '0;
   logic [7:0]  cal_h6 = '0;

   logic [ReqDataWidth-1:0] raw_queue[$];
   comp_reading_type        expected_readings[$];

   bit idle_on = 1'b1;
   bit long_stall_req = 1'b0;
   bit long_stall_done = 1'b0;
   int send_gap = 0;
   int stall_left = 0;
   int idle_cycles = 0;
   int error_count = 0;
   int items_sent = 0;
   int results_checked = 0;
   int sat_seen = 0;
   int clamp_seen = 0;
   int cal_sets = 1;

   temp_humidity_compensation u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // 32-bit wrapping integer compensation of one raw measurement
   function automatic comp_reading_type compensate(input logic [ReqDataWidth-1:0] raw);
      int t1, t2, t3, h1, h2, h3, h4, h5, h6, h7;
      int adc_t, adc_h, a, b, c, half, fine, tc;
      int g1, g2, gsum, q, r, w, sq, v6, hum;
      comp_reading_type res;
      t1 = int'(cal_t1);
      t2 = int'($signed(cal_t2));
      t3 = int'($signed(cal_t3));
      h1 = int'(cal_h1);
      h2 = int'(cal_h2);
      h3 = int'($signed(cal_hbytes[7:0]));
      h4 = int'($signed(cal_hbytes[15:8]));
      h5 = int'($signed(cal_hbytes[23:16]));
      h7 = int'($signed(cal_hbytes[31:24]));
      h6 = int'(cal_h6);
      adc_t = int'({raw[7:0], raw[15:8], raw[23:20]});
      adc_h = int'({raw[31:24], raw[39:32]});

      a = (adc_t >>> 3) - (t1 <<< 1);
      b = (a * t2) >>> 11;
      half = a >>> 1;
      c = (half * half) >>> 12;
      c = (c * (t3 <<< 4)) >>> 14;
      fine = b + c;
      tc = (fine * 5 + 128) >>> 8;
      res.sat = (tc > 32767) || (tc < -32768);
      if (tc > 32767) begin
         res.temperature = 16'h7FFF;
      end else if (tc < -32768) begin
         res.temperature = 16'h8000;
      end else begin
         res.temperature = tc[15:0];
      end

      a = adc_h - (h1 <<< 4) - (((tc * h3) / 100) >>> 1);
      g1 = (tc * h4) / 100;
      g2 = (tc * h5) / 100;
      g2 = ((tc * g2) >>> 6) / 100;
      gsum = g1 + g2 + 16384;
      b = (h2 * gsum) >>> 10;
      q = a * b;
      w = ((h6 <<< 7) + (tc * h7) / 100) >>> 4;
      r = q >>> 14;
      sq = (r * r) >>> 10;
      v6 = (w * sq) >>> 1;
      hum = (((q + v6) >>> 10) * 1000) >>> 12;
      if (hum < 0) begin
         res.humidity = '0;
      end else if (hum > 100000) begin
         res.humidity = HumMax;
      end else begin
         res.humidity = hum[HumWidth-1:0];
      end
      return res;
   endfunction

   function automatic logic [ReqDataWidth-1:0] pack_raw(input logic [7:0] t_msb,
         input logic [7:0] t_lsb, input logic [7:0] t_xlsb, input logic [7:0] h_msb,
         input logic [7:0] h_lsb);
      return {h_lsb, h_msb, t_xlsb, t_lsb, t_msb};
   endfunction

   function automatic logic [ReqDataWidth-1:0] typical_raw();
      logic [19:0] adc_t;
      logic [15:0] adc_h;
      adc_t = 20'($urandom_range(300000, 600000));
      adc_h = 16'($urandom_range(15000, 45000));
      return pack_raw(adc_t[19:12], adc_t[11:4], {adc_t[3:0], 4'($urandom)},
                      adc_h[15:8], adc_h[7:0]);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_readings.push_back(compensate(req_tdata));
            items_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (raw_queue.size() > 0) begin
               if (idle_on && $urandom_range(0, 7) == 0) begin
                  send_gap = $urandom_range(0, 3);
                  req_tvalid <= 1'b0;
               end else begin
                  req_tvalid <= 1'b1;
                  req_tdata <= raw_queue.pop_front();
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor and checker
   always @(posedge clock) begin
      comp_reading_type exp_r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_readings.size() == 0) begin
               error_count++;
               $error("unexpected result transaction, data %h", rsp_tdata);
            end else begin
               exp_r = expected_readings.pop_front();
               results_checked++;
               if (exp_r.sat) sat_seen++;
               if (exp_r.humidity == '0 || exp_r.humidity == HumMax) clamp_seen++;
               if (rsp_tdata[TempWidth-1:0] !== exp_r.temperature) begin
                  error_count++;
                  if (error_count <= MaxReports)
                     $error("temperature_centideg: expected %0d, actual %0d",
                            $signed(exp_r.temperature), $signed(rsp_tdata[TempWidth-1:0]));
               end
               if (rsp_tdata[TempWidth +: HumWidth] !== exp_r.humidity) begin
                  error_count++;
                  if (error_count <= MaxReports)
                     $error("humidity_millipct: expected %0d, actual %0d",
                            exp_r.humidity, rsp_tdata[TempWidth +: HumWidth]);
               end
               if (rsp_tuser[0] !== exp_r.sat) begin
                  error_count++;
                  if (error_count <= MaxReports)
                     $error("temp_saturated: expected %0b, actual %0b",
                            exp_r.sat, rsp_tuser[0]);
               end
            end
         end
         if (long_stall_req && !long_stall_done) begin
            long_stall_done = 1'b1;
            stall_left = LongStallCycles;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
                   (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_csr(input logic [CsrIndexWidth-1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_TEMP_CAL_ONE:         cal_t1 = value[15:0];
         CSR_TEMP_CAL_TWO:         cal_t2 = value[15:0];
         CSR_TEMP_CAL_THREE:       cal_t3 = value[7:0];
         CSR_HUM_CAL_ONE:          cal_h1 = value[11:0];
         CSR_HUM_CAL_TWO:          cal_h2 = value[11:0];
         CSR_HUM_CAL_SIGNED_BYTES: cal_hbytes = value;
         CSR_HUM_CAL_SIX:          cal_h6 = value[7:0];
         default: ;
      endcase
   endtask

   // unused upper data bits carry noise, the block must drop them
   task automatic load_cal(input logic [15:0] t1, input logic [15:0] t2, input logic [7:0] t3,
         input logic [11:0] h1, input logic [11:0] h2, input logic [31:0] hbytes,
         input logic [7:0] h6);
      write_csr(CSR_TEMP_CAL_ONE, {16'($urandom), t1});
      write_csr(CSR_TEMP_CAL_TWO, {16'($urandom), t2});
      write_csr(CSR_TEMP_CAL_THREE, {24'($urandom), t3});
      write_csr(CSR_HUM_CAL_ONE, {20'($urandom), h1});
      write_csr(CSR_HUM_CAL_TWO, {20'($urandom), h2});
      write_csr(CSR_HUM_CAL_SIGNED_BYTES, hbytes);
      write_csr(CSR_HUM_CAL_SIX, {24'($urandom), h6});
      cal_sets++;
   endtask

   task automatic load_typical_cal();
      load_cal(16'($urandom_range(25000, 29000)), 16'($urandom_range(25000, 27000)),
               8'($urandom_range(0, 6)), 12'($urandom_range(600, 900)),
               12'($urandom_range(900, 1100)),
               {8'($urandom_range(156, 166)) | 8'h80, 8'($urandom_range(15, 25)),
                8'($urandom_range(40, 50)), 8'($urandom_range(0, 3))},
               8'($urandom_range(110, 130)));
   endtask

   // settle, then look again so a request launched on the same edge is not missed
   task automatic wait_drained();
      do begin
         while (raw_queue.size() != 0 || req_tvalid || expected_readings.size() != 0)
            @(posedge clock);
         repeat (DrainCycles) @(posedge clock);
      end while (raw_queue.size() != 0 || req_tvalid || expected_readings.size() != 0);
   endtask

   task automatic queue_corner_readings();
      raw_queue.push_back(pack_raw(8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      raw_queue.push_back(pack_raw(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      raw_queue.push_back(pack_raw(8'hFF, 8'hFF, 8'hF0, 8'h00, 8'h00));
      raw_queue.push_back(pack_raw(8'h00, 8'h00, 8'h0F, 8'hFF, 8'hFF));
      raw_queue.push_back(pack_raw(8'h7A, 8'h32, 8'h50, 8'h66, 8'h40));
      raw_queue.push_back(pack_raw(8'h55, 8'hAA, 8'h5A, 8'hAA, 8'h55));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset calibration, then typical, then both extremes
      queue_corner_readings();
      wait_drained();
      load_typical_cal();
      queue_corner_readings();
      wait_drained();
      load_cal(16'hFFFF, 16'h7FFF, 8'h7F, 12'hFFF, 12'hFFF, 32'h7F7F7F7F, 8'hFF);
      queue_corner_readings();
      wait_drained();
      load_cal(16'h0000, 16'h8000, 8'h80, 12'h000, 12'hFFF, 32'h80808080, 8'h00);
      write_csr(CsrUnmapped, $urandom);
      queue_corner_readings();
      wait_drained();

      for (int p = 0; p < RandomPhases; p++) begin
         if (p % 2 == 0) begin
            load_typical_cal();
         end else begin
            load_cal(16'($urandom), 16'($urandom), 8'($urandom), 12'($urandom),
                     12'($urandom), $urandom, 8'($urandom));
         end
         if (p == 2) long_stall_req = 1'b1;
         if (p == RandomPhases - 1) idle_on = 1'b0;
         for (int n = 0; n < ItemsPerPhase; n++) begin
            if (p % 2 == 0 && $urandom_range(0, 4) != 0)
               raw_queue.push_back(typical_raw());
            else
               raw_queue.push_back({8'($urandom), 32'($urandom)});
         end
         wait_drained();
      end

      if (expected_readings.size() != 0) begin
         error_count++;
         $error("%0d results never arrived", expected_readings.size());
      end
      $display("ran %0d measurements under %0d calibration sets, %0d results checked",
               items_sent, cal_sets, results_checked);
      $display("%0d saturated temperatures, %0d clamped humidities, %0d mismatches",
               sat_seen, clamp_seen, error_count);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: sim.f
hw/rtl/tmpc_pkg.sv
hw/rtl/tmpc_csr.sv
hw/rtl/tmpc_flow.sv
hw/rtl/tmpc_temp.sv
hw/rtl/tmpc_hum.sv
hw/rtl/temp_humidity_compensation.sv
hw/rtl/tmpc_checker.sv
dv/temp_humidity_compensation_tb.sv
